// File: hw/rtl/qco_pkg.sv
package qco_pkg;

    localparam int unsigned PHASE_BITS_DEF  = 32;
    localparam int unsigned TABLE_BITS_DEF  = 10;
    localparam int unsigned LENGTH_BITS_DEF = 24;

    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned CFG_ADDR_BITS = 3;
    localparam int unsigned AMP_BITS      = 16;
    localparam int unsigned ROM_BITS      = 16;
    localparam int unsigned SAMPLE_BITS   = 20;
    localparam int unsigned STATUS_BITS   = 2;
    localparam int unsigned WLEN_CFG_BITS = 24;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_START_PHASE  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_AMPLITUDE    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_COMPLEX_MODE = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WAVE_LENGTH  = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO_STEP = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO_LEN  = 2'd2;

    localparam logic [AMP_BITS-1:0] AMP_RESET = 16'd4096;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned SERIES_TERMS = 10;
    localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // quarter-wave sine entry, Q1.15, from a truncated Q2.30 Taylor series
    function automatic logic [ROM_BITS-1:0] rom_entry(input int unsigned k,
                                                      input int unsigned table_bits);
        logic [63:0]        half;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        prod;
        half = (64'd1 << table_bits) >> 1;
        x    = (64'(k) * HALF_PI_Q30 + half) >> table_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 0; n < SERIES_TERMS; n++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[n];
            if ((n % 2) == 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        prod = unsigned'(sum) * 64'd32767 + (64'd1 << 29);
        return prod[30 +: ROM_BITS];
    endfunction

endpackage

// File: hw/rtl/quadrature_cosine_oscillator_top.sv
// Quadrature cosine oscillator.
// Input channel (i_in_valid / o_in_ready) carries one request transaction
// with i_restart; each request gives exactly one result transaction on the
// output channel (o_out_valid / i_out_ready): amplitude*cos and, in complex
// mode, amplitude*sin of the running phase, plus last and status.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_addr, i_cfg_wdata), to be
// written only while no transaction is in flight; the block does not enforce this.
// Result path: stage 1 registers the phase at acceptance (state update), stage 2
// the quarter-wave ROM read, and the output register the amplitude multiply.
// Throughput: one request per cycle unless the output stalls; phase/index state
// lives in a one-entry synchronous memory, read, updated and written back each
// accepted request, with the last write forwarded to the next request.
// Reset: phase and index read as zero (valid flag), amplitude 1.0, other
// configuration registers and valid flags zero; no clearing pass is needed.
// Stall: a stalled receiver holds the output register; the two inner stages
// keep filling, so up to three results are held before o_in_ready drops.
module quadrature_cosine_oscillator_top
    import qco_pkg::*;
#(
    parameter int unsigned PHASE_BITS  = PHASE_BITS_DEF,
    parameter int unsigned TABLE_BITS  = TABLE_BITS_DEF,
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_cos_value,
    output logic signed [SAMPLE_BITS-1:0] o_sin_value,
    output logic                          o_last,
    output logic [STATUS_BITS-1:0]        o_status
);

    localparam int unsigned ROM_DEPTH = (1 << TABLE_BITS) + 1;
    localparam int unsigned ADDR_BITS = TABLE_BITS + 1;
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [ADDR_BITS-1:0]  FULL_IDX = ADDR_BITS'(1) << TABLE_BITS;

    typedef logic [ROM_BITS-1:0] t_rom_array [ROM_DEPTH];

    typedef struct packed {
        logic [PHASE_BITS-1:0]  phase;
        logic [LENGTH_BITS-1:0] index;
    } t_osc_state;

    function automatic t_rom_array build_rom();
        t_rom_array rom;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            rom[k] = rom_entry(k, TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom_array QUARTER_ROM = build_rom();

    function automatic logic [ADDR_BITS-1:0] rom_addr(input logic [PHASE_BITS-1:0] ph);
        logic [ADDR_BITS-1:0] idx;
        idx = {1'b0, ph[PHASE_BITS-3 -: TABLE_BITS]};
        return ph[PHASE_BITS-2] ? (FULL_IDX - idx) : idx;
    endfunction

    // configuration
    logic [PHASE_BITS-1:0]  r_phase_step;
    logic [PHASE_BITS-1:0]  r_start_phase;
    logic [AMP_BITS-1:0]    r_amplitude;
    logic                   r_complex_mode;
    logic [LENGTH_BITS-1:0] r_wave_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_start_phase  <= '0;
            r_amplitude    <= AMP_RESET;
            r_complex_mode <= 1'b0;
            r_wave_length  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_PHASE_STEP:   r_phase_step   <= PHASE_BITS'(i_cfg_wdata);
                CFG_START_PHASE:  r_start_phase  <= PHASE_BITS'(i_cfg_wdata);
                CFG_AMPLITUDE:    r_amplitude    <= i_cfg_wdata[AMP_BITS-1:0];
                CFG_COMPLEX_MODE: r_complex_mode <= i_cfg_wdata[0];
                CFG_WAVE_LENGTH:  r_wave_length  <= LENGTH_BITS'(i_cfg_wdata[WLEN_CFG_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic r_s1_vld;
    logic r_s2_vld;
    logic r_out_vld;
    logic out_free;
    logic s2_free;
    logic s2_go;
    logic s1_go;
    logic accept;

    assign out_free   = !r_out_vld || i_out_ready;
    assign s2_go      = r_s2_vld && out_free;
    assign s2_free    = !r_s2_vld || out_free;
    assign s1_go      = r_s1_vld && s2_free;
    assign o_in_ready = !r_s1_vld || s2_free;
    assign accept     = i_in_valid && o_in_ready;

    // state memory with forwarding of the last write
    t_osc_state r_state_mem [1];
    t_osc_state r_mem_q;
    t_osc_state r_fwd_data;
    logic       r_fwd_hit;
    logic       r_st_vld;
    t_osc_state cur_state;
    t_osc_state rs_state;
    t_osc_state n_state;
    logic [STATUS_BITS-1:0] n_status;
    logic       n_last;
    logic       is_last;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_state_mem[0] <= n_state;
        end
        r_mem_q    <= r_state_mem[0];
        r_fwd_data <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
            r_st_vld  <= 1'b0;
        end else begin
            r_fwd_hit <= accept;
            if (accept) begin
                r_st_vld <= 1'b1;
            end
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            cur_state = r_fwd_data;
        end else if (r_st_vld) begin
            cur_state = r_mem_q;
        end else begin
            cur_state = '0;
        end

        rs_state = cur_state;
        if (i_restart) begin
            rs_state.phase = r_start_phase;
            rs_state.index = '0;
        end

        is_last  = rs_state.index >= (r_wave_length - LENGTH_BITS'(1));
        n_state  = rs_state;
        n_last   = 1'b0;
        if (r_phase_step == '0) begin
            n_status = STATUS_ZERO_STEP;
        end else if (r_wave_length == '0) begin
            n_status = STATUS_ZERO_LEN;
        end else begin
            n_status = STATUS_OK;
            if (is_last) begin
                n_last        = 1'b1;
                n_state.phase = r_start_phase;
                n_state.index = '0;
            end else begin
                n_state.phase = rs_state.phase + r_phase_step;
                n_state.index = rs_state.index + LENGTH_BITS'(1);
            end
        end
    end

    // stage 1: phase of this sample
    logic [PHASE_BITS-1:0]  r_s1_phase;
    logic [STATUS_BITS-1:0] r_s1_status;
    logic                   r_s1_last;
    logic [PHASE_BITS-1:0]  cos_phase;

    assign cos_phase = r_s1_phase + QUARTER;

    // stage 2: ROM magnitudes and signs
    logic [ROM_BITS-1:0]    r_s2_cos_mag;
    logic [ROM_BITS-1:0]    r_s2_sin_mag;
    logic                   r_s2_cos_neg;
    logic                   r_s2_sin_neg;
    logic [STATUS_BITS-1:0] r_s2_status;
    logic                   r_s2_last;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_phase  <= rs_state.phase;
            r_s1_status <= n_status;
            r_s1_last   <= n_last;
        end
        if (s1_go) begin
            r_s2_cos_mag <= QUARTER_ROM[rom_addr(cos_phase)];
            r_s2_sin_mag <= QUARTER_ROM[rom_addr(r_s1_phase)];
            r_s2_cos_neg <= cos_phase[PHASE_BITS-1];
            r_s2_sin_neg <= r_s1_phase[PHASE_BITS-1];
            r_s2_status  <= r_s1_status;
            r_s2_last    <= r_s1_last;
        end
    end

    // output stage: amplitude scaling with rounding
    logic [31:0]            cos_prod;
    logic [31:0]            sin_prod;
    logic [SAMPLE_BITS-1:0] cos_mag;
    logic [SAMPLE_BITS-1:0] sin_mag;
    logic [SAMPLE_BITS-1:0] cos_val;
    logic [SAMPLE_BITS-1:0] sin_val;
    logic                   s2_ok;

    assign cos_prod = 32'(r_amplitude) * 32'(r_s2_cos_mag) + 32'd2048;
    assign sin_prod = 32'(r_amplitude) * 32'(r_s2_sin_mag) + 32'd2048;
    assign cos_mag  = cos_prod[12 +: SAMPLE_BITS];
    assign sin_mag  = sin_prod[12 +: SAMPLE_BITS];
    assign cos_val  = r_s2_cos_neg ? (SAMPLE_BITS'(0) - cos_mag) : cos_mag;
    assign sin_val  = r_s2_sin_neg ? (SAMPLE_BITS'(0) - sin_mag) : sin_mag;
    assign s2_ok    = r_s2_status == STATUS_OK;

    logic signed [SAMPLE_BITS-1:0] r_cos;
    logic signed [SAMPLE_BITS-1:0] r_sin;
    logic                          r_last;
    logic [STATUS_BITS-1:0]        r_status;

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_cos    <= s2_ok ? signed'(cos_val) : '0;
            r_sin    <= (s2_ok && r_complex_mode) ? signed'(sin_val) : '0;
            r_last   <= r_s2_last;
            r_status <= r_s2_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_s2_vld <= 1'b1;
            end else if (s2_go) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_go) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_cos_value = r_cos;
    assign o_sin_value = r_sin;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule

// File: bench/quadrature_cosine_oscillator_top_test.sv
`timescale 1ns / 100ps

module quadrature_cosine_oscillator_top_test;
    import qco_pkg::*;

    localparam int unsigned QUARTER_SIZE = 1 << TABLE_BITS_DEF;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned PHASE_ITEMS  = 104;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned PIPE_DEPTH   = 4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] cos_value;
        logic signed [SAMPLE_BITS-1:0] sin_value;
        logic                          last;
        logic [STATUS_BITS-1:0]        status;
    } t_sample;

    typedef struct {
        bit                       is_write;
        logic [CFG_ADDR_BITS-1:0] reg_idx;
        logic [CFG_DATA_BITS-1:0] wdata;
        bit                       restart;
        bit                       typed;
        t_sample                  want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0]      i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_wdata = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic                          i_restart = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_cos_value;
    logic signed [SAMPLE_BITS-1:0] o_sin_value;
    logic                          o_last;
    logic [STATUS_BITS-1:0]        o_status;

    quadrature_cosine_oscillator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cos_value (o_cos_value),
        .o_sin_value (o_sin_value),
        .o_last      (o_last),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    // oscillator image: registers, running phase and index, quarter-wave table
    logic [15:0]              quarter_wave [0:QUARTER_SIZE];
    logic [31:0]              step_reg;
    logic [31:0]              start_reg;
    logic [AMP_BITS-1:0]      amp_reg;
    logic                     cplx_reg;
    logic [WLEN_CFG_BITS-1:0] len_reg;
    logic [31:0]              phase_acc;
    logic [WLEN_CFG_BITS-1:0] sample_idx;

    t_sample     pending_samples [$];
    t_stim_row   plan [$];
    bit          quiet = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_used = 1'b0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned requests = 0;
    int unsigned samples_seen = 0;
    int unsigned vector_ends = 0;
    int unsigned error_status = 0;

    function automatic logic [15:0] sine_entry(int unsigned k);
        logic [63:0]    x;
        logic [63:0]    x2;
        logic [63:0]    term;
        longint signed  acc;
        x    = (64'(k) * HALF_PI_Q30 + (64'd1 << (TABLE_BITS_DEF - 1))) >> TABLE_BITS_DEF;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return 16'((64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic int signed table_sine(logic [31:0] ph);
        logic [1:0]                quad;
        logic [TABLE_BITS_DEF-1:0] pos;
        int signed                 v;
        quad = ph[31:30];
        pos  = ph[29 -: TABLE_BITS_DEF];
        v    = quad[0] ? int'(quarter_wave[QUARTER_SIZE - pos]) : int'(quarter_wave[pos]);
        return quad[1] ? -v : v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] apply_gain(int signed s);
        longint mag;
        longint r;
        mag = (s < 0) ? -s : s;
        r   = (longint'(amp_reg) * mag + 2048) >>> 12;
        return (s < 0) ? SAMPLE_BITS'(-r) : SAMPLE_BITS'(r);
    endfunction

    function automatic t_sample next_sample(bit restart);
        t_sample r;
        r = '0;
        if (restart) begin
            sample_idx = '0;
            phase_acc  = start_reg;
        end
        if (step_reg == 0) begin
            r.status = STATUS_ZERO_STEP;
        end else if (len_reg == 0) begin
            r.status = STATUS_ZERO_LEN;
        end else begin
            r.cos_value = apply_gain(table_sine(phase_acc + 32'h4000_0000));
            r.sin_value = cplx_reg ? apply_gain(table_sine(phase_acc)) : '0;
            r.status    = STATUS_OK;
            if (sample_idx >= len_reg - 1'b1) begin
                r.last     = 1'b1;
                sample_idx = '0;
                phase_acc  = start_reg;
            end else begin
                sample_idx = sample_idx + 1'b1;
                phase_acc  = phase_acc + step_reg;
            end
        end
        return r;
    endfunction

    function automatic t_stim_row row_write(logic [CFG_ADDR_BITS-1:0] idx,
                                            logic [CFG_DATA_BITS-1:0] data);
        t_stim_row r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.wdata    = data;
        return r;
    endfunction

    function automatic t_stim_row row_sample(bit restart);
        t_stim_row r;
        r         = '{default: '0};
        r.restart = restart;
        return r;
    endfunction

    function automatic t_stim_row row_typed(bit restart, int signed c, int signed s,
                                            bit last, logic [STATUS_BITS-1:0] status);
        t_stim_row r;
        r                = '{default: '0};
        r.restart        = restart;
        r.typed          = 1'b1;
        r.want.cos_value = SAMPLE_BITS'(c);
        r.want.sin_value = SAMPLE_BITS'(s);
        r.want.last      = last;
        r.want.status    = status;
        return r;
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PHASE_STEP:   step_reg  = data[31:0];
            CFG_START_PHASE:  start_reg = data[31:0];
            CFG_AMPLITUDE:    amp_reg   = data[AMP_BITS-1:0];
            CFG_COMPLEX_MODE: cplx_reg  = data[0];
            CFG_WAVE_LENGTH:  len_reg   = data[WLEN_CFG_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic offer_request(bit restart, t_sample want);
        while (!quiet && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_samples.push_back(want);
        requests++;
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_go && !hold_used) begin
            hold_used   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            samples_seen++;
            if (pending_samples.size() == 0) begin
                $error("result transaction with no request pending");
                mismatches++;
            end else begin
                want = pending_samples.pop_front();
                check_field("cos_value", want.cos_value, o_cos_value);
                check_field("sin_value", want.sin_value, o_sin_value);
                check_field("last", want.last, o_last);
                check_field("status", want.status, o_status);
                if (want.last) vector_ends++;
                if (want.status != STATUS_OK) error_status++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_stim_row   row;
        t_sample     want;
        logic [31:0] v;
        for (int k = 0; k <= QUARTER_SIZE; k++) begin
            quarter_wave[k] = sine_entry(k);
        end
        step_reg   = '0;
        start_reg  = '0;
        amp_reg    = AMP_RESET;
        cplx_reg   = 1'b0;
        len_reg    = '0;
        phase_acc  = '0;
        sample_idx = '0;

        plan.push_back(row_typed(1'b0, 0, 0, 1'b0, STATUS_ZERO_STEP));
        plan.push_back(row_typed(1'b1, 0, 0, 1'b0, STATUS_ZERO_STEP));
        plan.push_back(row_write(CFG_PHASE_STEP, 32'h0040_0000));
        plan.push_back(row_typed(1'b1, 0, 0, 1'b0, STATUS_ZERO_LEN));
        plan.push_back(row_write(CFG_WAVE_LENGTH, 32'd3));
        plan.push_back(row_sample(1'b1));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_write(CFG_AMPLITUDE, 32'd0));
        plan.push_back(row_typed(1'b1, 0, 0, 1'b0, STATUS_OK));
        plan.push_back(row_write(CFG_AMPLITUDE, 32'h0000_FFFF));
        plan.push_back(row_write(CFG_COMPLEX_MODE, 32'd1));
        plan.push_back(row_write(CFG_START_PHASE, 32'hFFFF_FFFF));
        plan.push_back(row_write(CFG_PHASE_STEP, 32'hFFFF_FFFF));
        plan.push_back(row_sample(1'b1));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_write(CFG_WAVE_LENGTH, 32'h00FF_FFFF));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_sample(1'b1));
        // shrink the vector below the running index
        plan.push_back(row_write(CFG_WAVE_LENGTH, 32'd1));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_sample(1'b1));
        plan.push_back(row_write(CFG_PHASE_STEP, 32'd0));
        plan.push_back(row_typed(1'b0, 0, 0, 1'b0, STATUS_ZERO_STEP));
        plan.push_back(row_write(CFG_WAVE_LENGTH, 32'd0));
        plan.push_back(row_typed(1'b1, 0, 0, 1'b0, STATUS_ZERO_STEP));
        plan.push_back(row_write(CFG_PHASE_STEP, 32'h1234_5678));
        plan.push_back(row_write(CFG_START_PHASE, 32'h4000_0000));
        plan.push_back(row_write(CFG_AMPLITUDE, 32'd4096));
        plan.push_back(row_write(CFG_COMPLEX_MODE, 32'd0));
        plan.push_back(row_write(CFG_WAVE_LENGTH, 32'd2));
        plan.push_back(row_sample(1'b1));
        plan.push_back(row_sample(1'b0));
        plan.push_back(row_sample(1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            row = plan[n];
            if (row.is_write) begin
                wait_drained();
                cfg_write(row.reg_idx, row.wdata);
            end else begin
                want = next_sample(row.restart);
                offer_request(row.restart, row.typed ? row.want : want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            quiet <= (p == 2);
            case ($urandom_range(9))
                0:       v = 32'd0;
                1:       v = 32'hFFFF_FFFF;
                2:       v = 32'd1;
                default: v = $urandom;
            endcase
            cfg_write(CFG_PHASE_STEP, v);
            case ($urandom_range(5))
                0:       v = 32'd0;
                1:       v = 32'hFFFF_FFFF;
                default: v = $urandom;
            endcase
            cfg_write(CFG_START_PHASE, v);
            case ($urandom_range(5))
                0:       v = 32'd0;
                1:       v = 32'h0000_FFFF;
                2:       v = 32'd4096;
                default: v = $urandom_range(16'hFFFF);
            endcase
            cfg_write(CFG_AMPLITUDE, v);
            cfg_write(CFG_COMPLEX_MODE, $urandom_range(1));
            case ($urandom_range(11))
                0:       v = 32'd0;
                1:       v = 32'd1;
                2:       v = 32'h00FF_FFFF;
                3:       v = $urandom_range(24'hFF_FFFF);
                default: v = $urandom_range(40, 2);
            endcase
            cfg_write(CFG_WAVE_LENGTH, v);
            if (p == 4) begin
                hold_go <= 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                bit restart;
                if (p == 6 && n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                restart = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 6);
                want    = next_sample(restart);
                offer_request(restart, want);
            end
        end

        quiet <= 1'b0;
        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        $display("Checked %0d requests against %0d samples over %0d register settings,",
                 requests, samples_seen, PHASES + 1);
        $display("  including %0d vector ends and %0d error statuses.",
                 vector_ends, error_status);
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
